// File: rtl/sed_pkg.sv
// Package with the types and constants of the score event detector.
package sed_pkg;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_ON_THRESHOLD  = 3'd0,
      CSR_OFF_THRESHOLD = 3'd1,
      CSR_MIN_ON_MS     = 3'd2,
      CSR_LED_HOLD_MS   = 3'd3,
      CSR_HANG_MS       = 3'd4,
      CSR_CLIP_DELAY_MS = 3'd5
   } csr_index_type;

   localparam logic [15:0] ON_THRESHOLD_RST  = 16'd52429;
   localparam logic [15:0] OFF_THRESHOLD_RST = 16'd32768;
   localparam logic [15:0] MIN_ON_MS_RST     = 16'd1000;
   localparam logic [15:0] LED_HOLD_MS_RST   = 16'd500;
   localparam logic [15:0] HANG_MS_RST       = 16'd3000;
   localparam logic [15:0] CLIP_DELAY_MS_RST = 16'd0;

   // Durations of 65536 s and more saturate; below that, ms / 1000 is
   // (ms / 8) * ceil(2^30 / 125) >> 30, exact for all values in range.
   localparam logic [31:0] DUR_SAT_MS   = 32'd65536000;
   localparam logic [23:0] DIV125_MUL   = 24'd8589935;
   localparam int          DIV125_SHIFT = 30;

   typedef struct packed {
      logic [15:0]        score;
      logic signed [15:0] level_db;
      logic [31:0]        now_ms;
   } req_type;

   typedef struct packed {
      logic               led_hot;
      logic               event_active;
      logic               event_started;
      logic               clip_begin;
      logic               clip_write;
      logic               event_ended;
      logic [15:0]        event_secs;
      logic signed [15:0] peak_level_db;
      logic [15:0]        peak_score;
      logic               has_clip;
   } rsp_type;

   typedef struct packed {
      logic [15:0] on_threshold;
      logic [15:0] off_threshold;
      logic [15:0] min_on_ms;
      logic [15:0] led_hold_ms;
      logic [15:0] hang_ms;
      logic [15:0] clip_delay_ms;
   } cfg_type;

   typedef struct packed {
      logic               led_hot;
      logic               event_active;
      logic               event_started;
      logic               clip_begin;
      logic               clip_write;
      logic               event_ended;
      logic [31:0]        elapsed_ms;
      logic signed [15:0] peak_level_db;
      logic [15:0]        peak_score;
      logic               has_clip;
   } mid_type;

endpackage

// File: rtl/sed_csr.sv
// Configuration registers of the score event detector.
module sed_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [sed_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [sed_pkg::CSR_DATA_W-1:0]    csr_data,
   output sed_pkg::cfg_type                  cfg
);
   import sed_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_ON_THRESHOLD:  cfg_in.on_threshold  = csr_data;
            CSR_OFF_THRESHOLD: cfg_in.off_threshold = csr_data;
            CSR_MIN_ON_MS:     cfg_in.min_on_ms     = csr_data;
            CSR_LED_HOLD_MS:   cfg_in.led_hold_ms   = csr_data;
            CSR_HANG_MS:       cfg_in.hang_ms       = csr_data;
            CSR_CLIP_DELAY_MS: cfg_in.clip_delay_ms = csr_data;
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.on_threshold  <= ON_THRESHOLD_RST;
         cfg_ff.off_threshold <= OFF_THRESHOLD_RST;
         cfg_ff.min_on_ms     <= MIN_ON_MS_RST;
         cfg_ff.led_hold_ms   <= LED_HOLD_MS_RST;
         cfg_ff.hang_ms       <= HANG_MS_RST;
         cfg_ff.clip_delay_ms <= CLIP_DELAY_MS_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// File: rtl/sed_core.sv
// Detector state and its single-step update for one registered input item.
module sed_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              step_en,
   input  sed_pkg::cfg_type  cfg,
   input  sed_pkg::req_type  req,
   output sed_pkg::mid_type  mid
);
   import sed_pkg::*;

   logic               active_ff, active_in;
   logic               above_valid_ff, above_valid_in;
   logic [31:0]        above_start_ff, above_start_in;
   logic               below_valid_ff, below_valid_in;
   logic [31:0]        below_start_ff, below_start_in;
   logic               led_on_ff, led_on_in;
   logic               led_above_valid_ff, led_above_valid_in;
   logic [31:0]        led_above_start_ff, led_above_start_in;
   logic [31:0]        event_start_ff, event_start_in;
   logic signed [15:0] max_level_ff, max_level_in;
   logic [15:0]        max_score_ff, max_score_in;
   logic               clip_pending_ff, clip_pending_in;
   logic [31:0]        clip_due_ff, clip_due_in;

   always_comb begin
      logic        present;
      logic        absent;
      logic [31:0] run_start;
      logic [31:0] clip_diff;

      present   = req.score >= cfg.on_threshold;
      absent    = req.score < cfg.off_threshold;
      run_start = 32'd0;
      clip_diff = req.now_ms - clip_due_ff;

      active_in          = active_ff;
      above_valid_in     = above_valid_ff;
      above_start_in     = above_start_ff;
      below_valid_in     = below_valid_ff;
      below_start_in     = below_start_ff;
      led_on_in          = led_on_ff;
      led_above_valid_in = led_above_valid_ff;
      led_above_start_in = led_above_start_ff;
      event_start_in     = event_start_ff;
      max_level_in       = max_level_ff;
      max_score_in       = max_score_ff;
      clip_pending_in    = clip_pending_ff;
      clip_due_in        = clip_due_ff;
      mid                = '0;

      if (present) begin
         led_above_valid_in = 1'b1;
         led_above_start_in = led_above_valid_ff ? led_above_start_ff : req.now_ms;
         if ((req.now_ms - led_above_start_in) >= 32'(cfg.led_hold_ms)) begin
            led_on_in = 1'b1;
         end
      end else if (absent) begin
         led_on_in          = 1'b0;
         led_above_valid_in = 1'b0;
      end else begin
         led_above_valid_in = 1'b0;
      end

      if (!active_ff) begin
         if (present) begin
            above_valid_in = 1'b1;
            above_start_in = above_valid_ff ? above_start_ff : req.now_ms;
            if ((req.now_ms - above_start_in) >= 32'(cfg.min_on_ms)) begin
               active_in         = 1'b1;
               mid.event_started = 1'b1;
               event_start_in    = above_start_in;
               max_level_in      = req.level_db;
               max_score_in      = req.score;
               below_valid_in    = 1'b0;
               clip_pending_in   = 1'b1;
               clip_due_in       = req.now_ms + 32'(cfg.clip_delay_ms);
            end
         end else begin
            above_valid_in = 1'b0;
         end
      end else begin
         if (clip_pending_ff) begin
            if (!clip_diff[31]) begin
               clip_pending_in = 1'b0;
               mid.clip_begin  = 1'b1;
            end
         end else begin
            mid.clip_write = 1'b1;
         end
         if (req.level_db > max_level_ff) begin
            max_level_in = req.level_db;
         end
         if (req.score > max_score_ff) begin
            max_score_in = req.score;
         end
         if (absent) begin
            below_valid_in = 1'b1;
            run_start      = below_valid_ff ? below_start_ff : req.now_ms;
            below_start_in = run_start;
            if ((req.now_ms - run_start) >= 32'(cfg.hang_ms)) begin
               mid.event_ended   = 1'b1;
               mid.elapsed_ms    = req.now_ms - event_start_ff;
               mid.peak_level_db = max_level_in;
               mid.peak_score    = max_score_in;
               mid.has_clip      = !clip_pending_in;
               clip_pending_in   = 1'b0;
               active_in         = 1'b0;
               above_valid_in    = 1'b0;
               below_valid_in    = 1'b0;
            end
         end else begin
            below_valid_in = 1'b0;
         end
      end

      mid.led_hot      = led_on_in;
      mid.event_active = active_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff          <= 1'b0;
         above_valid_ff     <= 1'b0;
         above_start_ff     <= '0;
         below_valid_ff     <= 1'b0;
         below_start_ff     <= '0;
         led_on_ff          <= 1'b0;
         led_above_valid_ff <= 1'b0;
         led_above_start_ff <= '0;
         event_start_ff     <= '0;
         max_level_ff       <= '0;
         max_score_ff       <= '0;
         clip_pending_ff    <= 1'b0;
         clip_due_ff        <= '0;
      end else if (step_en) begin
         active_ff          <= active_in;
         above_valid_ff     <= above_valid_in;
         above_start_ff     <= above_start_in;
         below_valid_ff     <= below_valid_in;
         below_start_ff     <= below_start_in;
         led_on_ff          <= led_on_in;
         led_above_valid_ff <= led_above_valid_in;
         led_above_start_ff <= led_above_start_in;
         event_start_ff     <= event_start_in;
         max_level_ff       <= max_level_in;
         max_score_ff       <= max_score_in;
         clip_pending_ff    <= clip_pending_in;
         clip_due_ff        <= clip_due_in;
      end
   end

endmodule

// File: rtl/sed_dur.sv
// Conversion of an elapsed time in milliseconds to whole seconds, saturating.
module sed_dur (
   input  logic [31:0] elapsed_ms,
   output logic [15:0] event_secs
);
   import sed_pkg::*;

   logic [22:0] eighths;
   logic [46:0] product;
   logic        sat;

   assign eighths    = elapsed_ms[25:3];
   assign product    = 47'(eighths) * 47'(DIV125_MUL);
   assign sat        = elapsed_ms >= DUR_SAT_MS;
   assign event_secs = sat ? 16'hFFFF : product[DIV125_SHIFT +: 16];

endmodule

// File: rtl/score_event_detector.sv
// Top level of the score event detector: handshakes, pipeline and outputs.
//
// Each transfer on the request channel produces exactly one response. An item
// passes three registers: the input register, a stage that holds the result
// of the detector state update, and the response register; the duration
// divide by 1000 (one multiply) sits between the last two. The response is
// valid once the item has moved from the input register through the update
// stage into the response register. One item is taken every cycle while the
// response side keeps up; ready is chained through the stages within the same
// cycle, so empty stages keep accepting while a response waits, and the input
// stalls only once all three stages hold an item. Configuration writes are
// taken every cycle and should be issued only when no item is in flight.
module score_event_detector (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  sed_pkg::req_type                req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output sed_pkg::rsp_type                rsp_data,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [sed_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [sed_pkg::CSR_DATA_W-1:0]  csr_data
);
   import sed_pkg::*;

   cfg_type     cfg;
   logic        s0_valid_ff, s0_valid_in;
   req_type     s0_req_ff;
   logic        s1_valid_ff, s1_valid_in;
   mid_type     s1_mid_ff;
   logic        s2_valid_ff, s2_valid_in;
   rsp_type     s2_rsp_ff;
   rsp_type     s2_rsp_in;
   mid_type     mid;
   logic [15:0] event_secs;
   logic        s0_ready, s1_ready, s2_ready;
   logic        s0_fire, s1_fire;

   sed_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   sed_core u_core (
      .clock   (clock),
      .reset   (reset),
      .step_en (s0_fire),
      .cfg     (cfg),
      .req     (s0_req_ff),
      .mid     (mid)
   );

   sed_dur u_dur (
      .elapsed_ms (s1_mid_ff.elapsed_ms),
      .event_secs (event_secs)
   );

   assign s2_ready  = !s2_valid_ff || rsp_ready;
   assign s1_ready  = !s1_valid_ff || s2_ready;
   assign s0_ready  = !s0_valid_ff || s1_ready;
   assign req_ready = s0_ready;
   assign s0_fire   = s0_valid_ff && s1_ready;
   assign s1_fire   = s1_valid_ff && s2_ready;

   assign s0_valid_in = req_valid ? 1'b1 : (s0_valid_ff && !s1_ready);
   assign s1_valid_in = s0_fire ? 1'b1 : (s1_valid_ff && !s2_ready);
   assign s2_valid_in = s1_fire ? 1'b1 : (s2_valid_ff && !rsp_ready);

   always_comb begin
      s2_rsp_in.led_hot       = s1_mid_ff.led_hot;
      s2_rsp_in.event_active  = s1_mid_ff.event_active;
      s2_rsp_in.event_started = s1_mid_ff.event_started;
      s2_rsp_in.clip_begin    = s1_mid_ff.clip_begin;
      s2_rsp_in.clip_write    = s1_mid_ff.clip_write;
      s2_rsp_in.event_ended   = s1_mid_ff.event_ended;
      s2_rsp_in.event_secs    = event_secs;
      s2_rsp_in.peak_level_db = s1_mid_ff.peak_level_db;
      s2_rsp_in.peak_score    = s1_mid_ff.peak_score;
      s2_rsp_in.has_clip      = s1_mid_ff.has_clip;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s0_valid_ff <= s0_ready ? s0_valid_in : s0_valid_ff;
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && s0_ready) begin
         s0_req_ff <= req_data;
      end
      if (s0_fire) begin
         s1_mid_ff <= mid;
      end
      if (s1_fire) begin
         s2_rsp_ff <= s2_rsp_in;
      end
   end

   assign rsp_valid = s2_valid_ff;
   assign rsp_data  = s2_rsp_ff;

`ifndef SYNTHESIS
   // Summary fields are only carried by the response that ends an event.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.event_ended |->
         rsp_data.event_secs == 16'd0 && rsp_data.peak_level_db == 16'sd0 &&
         rsp_data.peak_score == 16'd0 && !rsp_data.has_clip)
      else $error("summary fields set without an event end");

   // The step that starts an event does no clip work and leaves it active.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.event_started |->
         rsp_data.event_active && !rsp_data.clip_begin && !rsp_data.clip_write &&
         !rsp_data.event_ended)
      else $error("event start response carries clip or end flags");

   // An ended event is no longer active, and a clip cannot open and stream at once.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.event_ended && rsp_data.event_active) &&
         !(rsp_data.clip_begin && rsp_data.clip_write))
      else $error("inconsistent event or clip flags");

   // An item held in the input stage stays there until the next stage takes it.
   assert property (@(posedge clock) disable iff (reset)
      s0_valid_ff && !s1_ready |=> s0_valid_ff && $stable(s0_req_ff))
      else $error("stalled input item lost or changed");
`endif

endmodule

// File: verif/score_event_detector_tb.sv
// Self-checking testbench of the score event detector with its own detector model.
module score_event_detector_tb;
   import sed_pkg::*;

   localparam int RESET_CYCLES    = 2;
   localparam int SETTLE_CYCLES   = 8;
   localparam int HOLD_OFF_CYCLES = 150;
   localparam int WATCHDOG_LIMIT  = 4000;
   localparam int REPORT_LIMIT    = 10;

   localparam logic [CSR_INDEX_W-1:0] CSR_UNMAPPED_A = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNMAPPED_B = 3'd7;

   localparam logic [31:0] MS_PER_S    = 32'd1000;
   localparam logic [31:0] DUR_LIMIT_S = 32'd65535;

   typedef enum int {MODE_PRESENT, MODE_ABSENT, MODE_MIDDLE, MODE_NOISE} score_mode_type;

   class event_tracker_type;
      logic [15:0]        on_thr;
      logic [15:0]        off_thr;
      logic [15:0]        min_on;
      logic [15:0]        led_confirm;
      logic [15:0]        hang;
      logic [15:0]        clip_delay;
      bit                 active;
      bit                 above_valid;
      bit                 below_valid;
      bit                 led_on;
      bit                 led_above_valid;
      bit                 clip_pending;
      logic [31:0]        above_start;
      logic [31:0]        below_start;
      logic [31:0]        led_above_start;
      logic [31:0]        event_start;
      logic [31:0]        clip_due;
      logic signed [15:0] max_level;
      logic [15:0]        max_score;
      rsp_type            awaited[$];
      int                 n_updates;
      int                 n_checked;
      int                 n_writes;
      int                 n_started;
      int                 n_ended;
      int                 n_clipped;
      int                 n_saturated;
      int                 n_errors;

      function new();
         on_thr          = ON_THRESHOLD_RST;
         off_thr         = OFF_THRESHOLD_RST;
         min_on          = MIN_ON_MS_RST;
         led_confirm     = LED_HOLD_MS_RST;
         hang            = HANG_MS_RST;
         clip_delay      = CLIP_DELAY_MS_RST;
         above_start     = '0;
         below_start     = '0;
         led_above_start = '0;
         event_start     = '0;
         clip_due        = '0;
         max_level       = '0;
         max_score       = '0;
      endfunction

      function void write_reg(logic [CSR_INDEX_W-1:0] idx, logic [15:0] value);
         n_writes++;
         case (idx)
            CSR_ON_THRESHOLD:  on_thr = value;
            CSR_OFF_THRESHOLD: off_thr = value;
            CSR_MIN_ON_MS:     min_on = value;
            CSR_LED_HOLD_MS:   led_confirm = value;
            CSR_HANG_MS:       hang = value;
            CSR_CLIP_DELAY_MS: clip_delay = value;
            default: ;
         endcase
      endfunction

      function int pending();
         return awaited.size();
      endfunction

      function void note_update(req_type item);
         rsp_type     outcome;
         logic [31:0] now;
         logic [31:0] since_due;
         logic [31:0] dur;
         bit          present;
         bit          absent;
         now     = item.now_ms;
         present = item.score >= on_thr;
         absent  = item.score < off_thr;
         outcome = '0;
         n_updates++;

         if (present) begin
            if (!led_above_valid) begin
               led_above_valid = 1'b1;
               led_above_start = now;
            end
            if (now - led_above_start >= {16'd0, led_confirm}) led_on = 1'b1;
         end else if (absent) begin
            led_on          = 1'b0;
            led_above_valid = 1'b0;
         end else begin
            led_above_valid = 1'b0;
         end

         if (!active) begin
            if (present) begin
               if (!above_valid) begin
                  above_valid = 1'b1;
                  above_start = now;
               end
               if (now - above_start >= {16'd0, min_on}) begin
                  active                = 1'b1;
                  outcome.event_started = 1'b1;
                  event_start           = above_start;
                  max_level             = item.level_db;
                  max_score             = item.score;
                  below_valid           = 1'b0;
                  clip_pending          = 1'b1;
                  clip_due              = now + {16'd0, clip_delay};
                  n_started++;
               end
            end else begin
               above_valid = 1'b0;
            end
         end else begin
            if (clip_pending) begin
               since_due = now - clip_due;
               if (!since_due[31]) begin
                  clip_pending       = 1'b0;
                  outcome.clip_begin = 1'b1;
               end
            end else begin
               outcome.clip_write = 1'b1;
            end
            if ($signed(item.level_db) > $signed(max_level)) max_level = item.level_db;
            if (item.score > max_score) max_score = item.score;

            if (absent) begin
               if (!below_valid) begin
                  below_valid = 1'b1;
                  below_start = now;
               end
               if (now - below_start >= {16'd0, hang}) begin
                  dur                   = (now - event_start) / MS_PER_S;
                  outcome.event_ended   = 1'b1;
                  outcome.event_secs    = (dur > DUR_LIMIT_S) ? DUR_LIMIT_S[15:0] : dur[15:0];
                  outcome.peak_level_db = max_level;
                  outcome.peak_score    = max_score;
                  outcome.has_clip      = !clip_pending;
                  n_ended++;
                  if (!clip_pending) n_clipped++;
                  if (dur > DUR_LIMIT_S) n_saturated++;
                  clip_pending = 1'b0;
                  active       = 1'b0;
                  above_valid  = 1'b0;
                  below_valid  = 1'b0;
               end
            end else begin
               below_valid = 1'b0;
            end
         end

         outcome.led_hot      = led_on;
         outcome.event_active = active;
         awaited.push_back(outcome);
      endfunction

      function void note_failure(string msg);
         n_errors++;
         if (n_errors <= REPORT_LIMIT) $display("%s", msg);
      endfunction

      function void check_field(string name, logic [31:0] want, logic [31:0] got);
         if (got !== want)
            note_failure($sformatf("result %0d, %s: expected %0h, got %0h",
                                   n_checked, name, want, got));
      endfunction

      function void check_outcome(rsp_type got);
         rsp_type want;
         if (awaited.size() == 0) begin
            note_failure($sformatf("result %h arrived with nothing outstanding", got));
            return;
         end
         want = awaited.pop_front();
         n_checked++;
         check_field("led_hot", 32'(want.led_hot), 32'(got.led_hot));
         check_field("event_active", 32'(want.event_active), 32'(got.event_active));
         check_field("event_started", 32'(want.event_started), 32'(got.event_started));
         check_field("clip_begin", 32'(want.clip_begin), 32'(got.clip_begin));
         check_field("clip_write", 32'(want.clip_write), 32'(got.clip_write));
         check_field("event_ended", 32'(want.event_ended), 32'(got.event_ended));
         check_field("event_secs", 32'(want.event_secs), 32'(got.event_secs));
         check_field("peak_level_db", 32'(want.peak_level_db), 32'(got.peak_level_db));
         check_field("peak_score", 32'(want.peak_score), 32'(got.peak_score));
         check_field("has_clip", 32'(want.has_clip), 32'(got.has_clip));
      endfunction
   endclass

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   req_type                req_data = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   rsp_type                rsp_data;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data = '0;

   event_tracker_type tracker = new();
   bit             no_idle = 1'b0;
   int             hold_off_asked = 0;
   int             hold_off_done = 0;
   int             stall_left = 0;
   int             idle_cycles = 0;
   logic [31:0]    now_track = 32'h0000_2000;
   score_mode_type mode = MODE_NOISE;
   int             mode_left = 0;
   int unsigned    step_max = 1000;

   score_event_detector u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int pick_gap();
      int unsigned r;
      if (no_idle) return 0;
      r = $urandom_range(99);
      if (r < 60) return 0;
      if (r < 93) return $urandom_range(3, 1);
      return $urandom_range(40, 8);
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready  <= 1'b0;
         stall_left <= 0;
      end else if (hold_off_done != hold_off_asked) begin
         hold_off_done <= hold_off_asked;
         stall_left    <= HOLD_OFF_CYCLES;
         rsp_ready     <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_ready  <= 1'b0;
      end else begin
         stall_left <= pick_gap();
         rsp_ready  <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) tracker.check_outcome(rsp_data);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("No transfer for %0d cycles.", idle_cycles);
         $display("[score_event_detector] ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic req_type make_req(input logic [15:0] score,
                                        input logic signed [15:0] level,
                                        input logic [31:0] now);
      req_type item;
      item.score    = score;
      item.level_db = level;
      item.now_ms   = now;
      return item;
   endfunction

   function automatic logic [15:0] pick_score(input score_mode_type m);
      int unsigned on_t;
      int unsigned off_t;
      on_t  = 32'(tracker.on_thr);
      off_t = 32'(tracker.off_thr);
      case (m)
         MODE_PRESENT: begin
            if ($urandom_range(9) == 0) return 16'(on_t);
            return 16'($urandom_range(65535, on_t));
         end
         MODE_ABSENT: begin
            if (off_t > 0) begin
               if ($urandom_range(9) == 0) return 16'(off_t - 1);
               return 16'($urandom_range(off_t - 1, 0));
            end
         end
         MODE_MIDDLE: begin
            if (off_t < on_t) begin
               if ($urandom_range(3) == 0) return 16'(off_t);
               return 16'($urandom_range(on_t - 1, off_t));
            end
         end
         default: ;
      endcase
      return 16'($urandom());
   endfunction

   function automatic req_type next_reading();
      req_type     item;
      int unsigned r;
      if (mode_left == 0) begin
         r = $urandom_range(99);
         if (r < 35) mode = MODE_PRESENT;
         else if (r < 70) mode = MODE_ABSENT;
         else if (r < 85) mode = MODE_MIDDLE;
         else mode = MODE_NOISE;
         mode_left = $urandom_range(12, 1);
      end
      mode_left--;
      r = $urandom_range(99);
      if (r < 2) now_track = $urandom();
      else if (r < 4) now_track = now_track - $urandom_range(step_max, 0);
      else now_track = now_track + $urandom_range(step_max, 0);
      item.score = pick_score(mode);
      r = $urandom_range(99);
      if (r < 5) item.level_db = 16'sh8000;
      else if (r < 10) item.level_db = 16'sh7FFF;
      else item.level_db = 16'($urandom());
      item.now_ms = now_track;
      return item;
   endfunction

   function automatic logic [15:0] rand_ms();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 8) return 16'd0;
      if (r < 14) return 16'hFFFF;
      return 16'($urandom_range(400));
   endfunction

   function automatic cfg_type random_config();
      cfg_type cfg;
      cfg.on_threshold  = 16'($urandom());
      cfg.off_threshold = 16'($urandom());
      cfg.min_on_ms     = rand_ms();
      cfg.led_hold_ms   = rand_ms();
      cfg.hang_ms       = rand_ms();
      cfg.clip_delay_ms = rand_ms();
      return cfg;
   endfunction

   function automatic int unsigned step_limit();
      int unsigned m;
      m = 32'(tracker.min_on);
      if (32'(tracker.led_confirm) > m) m = 32'(tracker.led_confirm);
      if (32'(tracker.hang) > m) m = 32'(tracker.hang);
      if (32'(tracker.clip_delay) > m) m = 32'(tracker.clip_delay);
      return m / 3 + 3;
   endfunction

   task automatic send_item(input req_type item);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      tracker.note_update(item);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (tracker.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic configure(input cfg_type cfg, input bit with_unmapped);
      logic [CSR_INDEX_W-1:0] idx_q[$];
      logic [15:0]            val_q[$];
      idx_q.push_back(CSR_ON_THRESHOLD);  val_q.push_back(cfg.on_threshold);
      idx_q.push_back(CSR_OFF_THRESHOLD); val_q.push_back(cfg.off_threshold);
      idx_q.push_back(CSR_MIN_ON_MS);     val_q.push_back(cfg.min_on_ms);
      idx_q.push_back(CSR_LED_HOLD_MS);   val_q.push_back(cfg.led_hold_ms);
      idx_q.push_back(CSR_HANG_MS);       val_q.push_back(cfg.hang_ms);
      idx_q.push_back(CSR_CLIP_DELAY_MS); val_q.push_back(cfg.clip_delay_ms);
      if (with_unmapped) begin
         idx_q.push_back(CSR_UNMAPPED_A); val_q.push_back(16'($urandom()));
         idx_q.push_back(CSR_UNMAPPED_B); val_q.push_back(16'($urandom()));
      end
      csr_valid <= 1'b1;
      foreach (idx_q[i]) begin
         csr_index <= idx_q[i];
         csr_data  <= val_q[i];
         do @(posedge clock); while (!csr_ready);
         tracker.write_reg(idx_q[i], val_q[i]);
      end
      csr_valid <= 1'b0;
   endtask

   task automatic run_random(input int n_items);
      repeat (n_items) send_item(next_reading());
   endtask

   task automatic run_phase(input cfg_type cfg, input bit with_unmapped, input bit quiet,
                            input bit squeeze, input int n_items);
      settle();
      no_idle <= quiet;
      configure(cfg, with_unmapped);
      step_max = step_limit();
      if (squeeze) hold_off_asked <= hold_off_asked + 1;
      run_random(n_items);
   endtask

   // Runs under the reset settings: confirm, start, clip, hang and end, then
   // timestamps that run backwards and wrap.
   task automatic run_directed();
      send_item(make_req(16'd0, 16'sd0, 32'd100));
      send_item(make_req(ON_THRESHOLD_RST, 16'sh8000, 32'd200));
      send_item(make_req(16'hFFFF, 16'sh7FFF, 32'd700));
      send_item(make_req(OFF_THRESHOLD_RST, 16'sd0, 32'd800));
      send_item(make_req(ON_THRESHOLD_RST, 16'sd50, 32'd900));
      send_item(make_req(16'd60000, -16'sd300, 32'd1900));
      send_item(make_req(OFF_THRESHOLD_RST - 16'd1, 16'sd100, 32'd1901));
      send_item(make_req(16'd0, 16'sh8000, 32'd1950));
      send_item(make_req(16'd40000, 16'sd20, 32'd2000));
      send_item(make_req(16'd10, 16'sd0, 32'd2100));
      send_item(make_req(16'd10, 16'sd0, 32'd5100));
      send_item(make_req(16'hFFFF, 16'sd0, 32'd5000));
      send_item(make_req(16'hFFFF, 16'sd7, 32'd4000));
      send_item(make_req(16'd0, -16'sd5, 32'd3000));
      send_item(make_req(16'd0, 16'sd0, 32'd2000));
      send_item(make_req(16'hFFFF, 16'sd0, 32'hFFFF_FF00));
      send_item(make_req(16'hFFFF, -16'sd1, 32'h0000_0300));
      send_item(make_req(16'd0, 16'sd1, 32'h0000_0400));
      send_item(make_req(16'hFFFF, 16'sh7FFF, 32'h0000_0500));
      send_item(make_req(16'd0, 16'sd0, 32'h0000_0600));
      send_item(make_req(16'd0, 16'sd0, 32'h0000_11B8));
   endtask

   initial begin
      cfg_type cfg;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      step_max = step_limit();
      run_directed();
      run_random(150);

      cfg = '{on_threshold: 16'd40000, off_threshold: 16'd20000, min_on_ms: 16'd30,
              led_hold_ms: 16'd10, hang_ms: 16'd50, clip_delay_ms: 16'd20};
      run_phase(cfg, 1'b1, 1'b1, 1'b1, 200);

      cfg = '{default: 16'hFFFF};
      run_phase(cfg, 1'b0, 1'b0, 1'b0, 150);

      cfg = '0;
      run_phase(cfg, 1'b0, 1'b0, 1'b0, 80);

      // On threshold below the off threshold, with very short times.
      cfg = '{on_threshold: 16'd20000, off_threshold: 16'd40000, min_on_ms: 16'd0,
              led_hold_ms: 16'd0, hang_ms: 16'd5, clip_delay_ms: 16'd3};
      run_phase(cfg, 1'b0, 1'b1, 1'b0, 200);

      for (int p = 0; p < 6; p++) run_phase(random_config(), p == 2, p % 2 == 1, 1'b0, 180);

      settle();
      $display("Checked %0d of %0d updates across eleven settings, %0d register writes.",
               tracker.n_checked, tracker.n_updates, tracker.n_writes);
      $display("Events: %0d started, %0d ended, %0d with a clip, %0d saturated; %0d mismatches.",
               tracker.n_started, tracker.n_ended, tracker.n_clipped, tracker.n_saturated,
               tracker.n_errors);
      if (tracker.n_errors == 0 && tracker.pending() == 0) begin
         $display("[score_event_detector] OK");
      end else begin
         $display("[score_event_detector] ERROR");
      end
      $finish;
   end

endmodule

// File: files.f
rtl/sed_pkg.sv
rtl/sed_csr.sv
rtl/sed_core.sv
rtl/sed_dur.sv
rtl/score_event_detector.sv
verif/score_event_detector_tb.sv
